>>> sv/wstoi_pkg.sv
// ---------------------------------------------------------------------------
// wstoi_pkg
// Shared types and constants for the wide string to integer unit.
// ---------------------------------------------------------------------------
package wstoi_pkg;

  localparam int CU_W        = 16;
  localparam int BASE_W      = 6;
  localparam int VALUE_W     = 64;
  localparam int POS_W       = 13;
  localparam int MAX_CHARS   = 4096;
  localparam int OUT_TDATA_W = 80;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [CU_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CU_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CU_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CU_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CU_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CU_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CU_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CU_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CU_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CU_W-1:0] CH_UZ    = 16'h005A;
  localparam logic [CU_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CU_W-1:0] CH_LZ    = 16'h007A;
  localparam logic [CU_W-1:0] CH_UX    = 16'h0058;
  localparam logic [CU_W-1:0] CH_LX    = 16'h0078;

  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

  localparam logic [VALUE_W-1:0] MAG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    PH_FINISHED,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // classified code unit
  typedef struct packed {
    logic              first;
    logic              term;
    logic              space;
    logic              plus;
    logic              minus;
    logic              zero;
    logic              hex_x;
    logic              alnum;
    logic [BASE_W-1:0] dval;
  } unit_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> sv/wide_string_to_integer_unit.sv
// ---------------------------------------------------------------------------
// wide_string_to_integer_unit
// strtol-style conversion of a 16-bit code unit stream to a signed 64-bit
// value, with saturation on overflow and the index of the stop unit.
// ---------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | tdata code_unit, tuser first_unit
//  out_    | out | out_tvalid / out_tready | tdata value, stop_index, overflowed
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data default_base
//
//  One item per cycle sustained while the output is not stalled; the back
//  end's combinational 64x6 multiply-add per unit allows that rate. A result
//  is registered twice on its way out: the queue write when its unit is taken,
//  then, once the output is free, the back-end step into the output register.
//  rst_n is synchronous; after reset the unit ignores items until one
//  carries first_unit. The 4-entry queue lets the input keep flowing while
//  the output is stalled; in_tready drops only once that queue is full.
// ---------------------------------------------------------------------------
module wide_string_to_integer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wstoi_pkg::CU_W-1:0]           in_tdata,   // code_unit[15:0]
  input  logic                                 in_tuser,   // first_unit
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // value[63:0], stop_index[76:64], overflowed[77], zero pad [79:78]
  output logic [wstoi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wstoi_pkg::BASE_W-1:0]         cfg_data    // default_base
);

  logic [wstoi_pkg::BASE_W-1:0] default_base_r;
  wstoi_pkg::q_stat_t           q_stat;
  wstoi_pkg::unit_t             push_item;
  wstoi_pkg::unit_t             pop_item;
  logic                         q_push;
  logic                         q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_base_r <= '0;
    end else if (cfg_valid) begin
      default_base_r <= cfg_data;
    end
  end

  wstoi_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  wstoi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  wstoi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .default_base (default_base_r),
    .q_stat       (q_stat),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_result_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(q_pop))
    else $error("result appeared without a queue pop");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[77]) |->
      (out_tdata[63:0] == wstoi_pkg::INT_MAX || out_tdata[63:0] == wstoi_pkg::MAG_CAP))
    else $error("overflow flagged without a saturated value");

  a_stop_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[76:64] <= 13'(wstoi_pkg::MAX_CHARS)))
    else $error("stop index beyond the count limit");
`endif

endmodule

>>> sv/wstoi_front.sv
// ---------------------------------------------------------------------------
// wstoi_front
// Input side: takes code units and classifies them for the back end.
// ---------------------------------------------------------------------------
module wstoi_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wstoi_pkg::CU_W-1:0]     in_tdata,   // code_unit
  input  logic                           in_tuser,   // first_unit
  input  wstoi_pkg::q_stat_t             q_stat,
  output logic                           q_push,
  output wstoi_pkg::unit_t               q_item
);

  logic [wstoi_pkg::CU_W-1:0] c;
  logic [wstoi_pkg::CU_W-1:0] ofs;
  logic                       is_dig;
  logic                       is_up;
  logic                       is_lo;

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;
  assign c         = in_tdata;

  assign is_dig = (c >= wstoi_pkg::CH_ZERO) && (c <= wstoi_pkg::CH_NINE);
  assign is_up  = (c >= wstoi_pkg::CH_UA) && (c <= wstoi_pkg::CH_UZ);
  assign is_lo  = (c >= wstoi_pkg::CH_LA) && (c <= wstoi_pkg::CH_LZ);

  always_comb begin
    if (is_dig) begin
      ofs = c - wstoi_pkg::CH_ZERO;
    end else if (is_up) begin
      ofs = c - wstoi_pkg::CH_UA + 16'(wstoi_pkg::LETTER_OFS);
    end else begin
      ofs = c - wstoi_pkg::CH_LA + 16'(wstoi_pkg::LETTER_OFS);
    end
  end

  always_comb begin
    q_item.first = in_tuser;
    q_item.term  = (c == wstoi_pkg::CH_NUL);
    q_item.space = (c == wstoi_pkg::CH_SPACE) ||
                   ((c >= wstoi_pkg::CH_TAB) && (c <= wstoi_pkg::CH_CR));
    q_item.plus  = (c == wstoi_pkg::CH_PLUS);
    q_item.minus = (c == wstoi_pkg::CH_MINUS);
    q_item.zero  = (c == wstoi_pkg::CH_ZERO);
    q_item.hex_x = (c == wstoi_pkg::CH_UX) || (c == wstoi_pkg::CH_LX);
    q_item.alnum = is_dig || is_up || is_lo;
    q_item.dval  = ofs[wstoi_pkg::BASE_W-1:0];
  end

endmodule

>>> sv/wstoi_queue.sv
// ---------------------------------------------------------------------------
// wstoi_queue
// Short FIFO of classified units between front and back end.
// ---------------------------------------------------------------------------
module wstoi_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wstoi_pkg::unit_t   push_item,
  input  logic               pop,
  output wstoi_pkg::unit_t   pop_item,
  output wstoi_pkg::q_stat_t stat
);

  wstoi_pkg::unit_t               mem [wstoi_pkg::QDEPTH];
  logic [wstoi_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [wstoi_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [wstoi_pkg::QCW-1:0]      count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign stat.full  = (count_r == wstoi_pkg::QCW'(wstoi_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/wstoi_back.sv
// ---------------------------------------------------------------------------
// wstoi_back
// Conversion state machine, multiply-accumulate and result register.
// ---------------------------------------------------------------------------
module wstoi_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [wstoi_pkg::BASE_W-1:0]         default_base,
  input  wstoi_pkg::q_stat_t                   q_stat,
  input  wstoi_pkg::unit_t                     q_item,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // value[63:0], stop_index[76:64], overflowed[77], zero pad [79:78]
  output logic [wstoi_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int PROD_W = wstoi_pkg::VALUE_W + wstoi_pkg::BASE_W;

  wstoi_pkg::phase_t                phase_r, phase_nxt, phase_c;
  logic [wstoi_pkg::VALUE_W-1:0]    acc_r, acc_nxt, acc_c;
  logic                             neg_r, neg_nxt, neg_c;
  logic [wstoi_pkg::BASE_W-1:0]     base_r, base_nxt, base_c, base_eff;
  logic [wstoi_pkg::POS_W-1:0]      pos_r, pos_nxt, pos_c;
  logic                             ovs_r, ovs_nxt, ovs_c;
  logic                             live;
  logic                             take;
  logic                             fin;
  logic [PROD_W-1:0]                sum;
  logic [wstoi_pkg::VALUE_W-1:0]    res_value;
  logic                             res_ovf;

  logic                             out_valid_r, out_valid_nxt;
  logic [wstoi_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                             step;

  assign step       = !q_stat.empty && (!out_valid_r || out_tready);
  assign q_pop      = step;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    phase_c = phase_r;
    acc_c   = acc_r;
    neg_c   = neg_r;
    base_c  = base_r;
    pos_c   = pos_r;
    ovs_c   = ovs_r;
    if (q_item.first) begin
      phase_c = wstoi_pkg::PH_SPACE;
      acc_c   = '0;
      neg_c   = 1'b0;
      base_c  = '0;
      pos_c   = '0;
      ovs_c   = 1'b0;
    end
    live = q_item.first || (phase_r != wstoi_pkg::PH_FINISHED);

    phase_nxt = phase_c;
    acc_nxt   = acc_c;
    neg_nxt   = neg_c;
    base_nxt  = base_c;
    pos_nxt   = pos_c;
    ovs_nxt   = ovs_c;
    take      = 1'b0;
    fin       = 1'b0;

    if (live) begin
      if (q_item.term) begin
        fin = 1'b1;
      end else begin
        unique case (phase_c)
          wstoi_pkg::PH_SPACE: begin
            if (q_item.space) begin
              phase_nxt = phase_c;
            end else if (q_item.plus || q_item.minus) begin
              neg_nxt   = q_item.minus;
              phase_nxt = wstoi_pkg::PH_SIGNED;
            end else if (q_item.zero) begin
              phase_nxt = wstoi_pkg::PH_ZERO;
            end else begin
              base_nxt = (default_base != '0) ? default_base : wstoi_pkg::BASE_DEC;
              take     = 1'b1;
            end
          end
          wstoi_pkg::PH_SIGNED: begin
            if (q_item.zero) begin
              phase_nxt = wstoi_pkg::PH_ZERO;
            end else begin
              base_nxt = (default_base != '0) ? default_base : wstoi_pkg::BASE_DEC;
              take     = 1'b1;
            end
          end
          wstoi_pkg::PH_ZERO: begin
            if (q_item.hex_x) begin
              base_nxt  = wstoi_pkg::BASE_HEX;
              phase_nxt = wstoi_pkg::PH_DIGITS;
            end else begin
              base_nxt = wstoi_pkg::BASE_OCT;
              take     = 1'b1;
            end
          end
          wstoi_pkg::PH_DIGITS: begin
            take = 1'b1;
          end
          default: begin
            phase_nxt = phase_c;
          end
        endcase
      end
    end

    // acc * base + digit; past 2^63 the magnitude saturates
    base_eff = (base_nxt != '0) ? base_nxt : wstoi_pkg::BASE_W'(1);
    sum = PROD_W'(acc_c) * PROD_W'(base_eff) + PROD_W'(q_item.dval);

    if (take) begin
      if (!q_item.alnum || (q_item.dval >= base_nxt)) begin
        fin = 1'b1;
      end else begin
        if (sum > PROD_W'(wstoi_pkg::MAG_CAP)) begin
          ovs_nxt = 1'b1;
          acc_nxt = wstoi_pkg::MAG_CAP;
        end else begin
          acc_nxt = sum[wstoi_pkg::VALUE_W-1:0];
        end
        phase_nxt = wstoi_pkg::PH_DIGITS;
      end
    end

    if (fin) begin
      phase_nxt = wstoi_pkg::PH_FINISHED;
    end else if (live && (pos_c < wstoi_pkg::POS_W'(wstoi_pkg::MAX_CHARS))) begin
      pos_nxt = pos_c + 1'b1;
    end

    res_ovf = ovs_c;
    if (neg_c) begin
      res_value = ovs_c ? wstoi_pkg::MAG_CAP : (~acc_c + 1'b1);
    end else if (ovs_c || acc_c[wstoi_pkg::VALUE_W-1]) begin
      res_ovf   = 1'b1;
      res_value = wstoi_pkg::INT_MAX;
    end else begin
      res_value = acc_c;
    end
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = fin;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wstoi_pkg::PH_FINISHED;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      base_r      <= '0;
      pos_r       <= '0;
      ovs_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
        ovs_r   <= ovs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && fin) begin
      out_data_r <= {2'b00, res_ovf, pos_c, res_value};
    end
  end

endmodule

>>> tb/tb_wide_string_to_integer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_wide_string_to_integer_unit
// Self-checking bench for the wide string to integer unit. A directed table
// covers prefixes, signs, saturation, odd bases and long strings; random
// strings follow under several base settings. Every result is checked against
// the table's expectation or a cycle-free predictor of the conversion, with
// random stalls on both streams and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_wide_string_to_integer_unit;
  import wstoi_pkg::*;

  localparam int DRAIN = 16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          stop;
    logic                      ovf;
  } conv_result_t;

  // one directed case: optional base write, leading spaces, text, tail unit
  typedef struct {
    int              base;
    int              pad;
    bit              lead;
    string           text;
    bit              has_tail;
    logic [CU_W-1:0] tail;
    bit              typed;
    logic [63:0]     v;
    int              stop;
    bit              ovf;
  } case_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [CU_W-1:0]        in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [BASE_W-1:0]      cfg_data = '0;

  // typed expectation travelling with the item on the bus
  logic                   tag_typed = 1'b0;
  conv_result_t           tag_exp = '0;

  conv_result_t           pending_results[$];
  int                     errors = 0;
  int                     rx_count = 0;
  bit                     steady = 1'b0;

  // predictor state
  logic [BASE_W-1:0]      base_reg = '0;
  phase_t                 ph = PH_FINISHED;
  logic [VALUE_W-1:0]     acc = '0;
  bit                     neg = 1'b0;
  int                     abase = 0;
  int                     pos = 0;
  bit                     ovs = 1'b0;

  wide_string_to_integer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // advance the conversion by one code unit
  task automatic convert_unit(input logic [CU_W-1:0] cu, input logic fu,
                              output bit done, output conv_result_t r);
    int          dv;
    bit          is_dig;
    bit          try_digit;
    logic [63:0] b;
    done = 1'b0;
    try_digit = 1'b0;
    r = '0;
    if (fu) begin
      ph = PH_SPACE;
      acc = '0;
      neg = 1'b0;
      abase = 0;
      pos = 0;
      ovs = 1'b0;
    end else if (ph == PH_FINISHED) begin
      return;
    end
    if (cu == CH_NUL) begin
      done = 1'b1;
    end else begin
      case (ph)
        PH_SPACE, PH_SIGNED: begin
          if (ph == PH_SPACE && (cu == CH_SPACE || (cu >= CH_TAB && cu <= CH_CR))) begin
          end else if (ph == PH_SPACE && (cu == CH_MINUS || cu == CH_PLUS)) begin
            neg = (cu == CH_MINUS);
            ph = PH_SIGNED;
          end else if (cu == CH_ZERO) begin
            ph = PH_ZERO;
          end else begin
            abase = (base_reg != 0) ? int'(base_reg) : int'(BASE_DEC);
            try_digit = 1'b1;
          end
        end
        PH_ZERO: begin
          if (cu == CH_LX || cu == CH_UX) begin
            abase = int'(BASE_HEX);
            ph = PH_DIGITS;
          end else begin
            abase = int'(BASE_OCT);
            try_digit = 1'b1;
          end
        end
        default: try_digit = 1'b1;
      endcase
    end
    if (try_digit) begin
      is_dig = 1'b1;
      dv = 0;
      if (cu >= CH_ZERO && cu <= CH_NINE) dv = int'(cu) - int'(CH_ZERO);
      else if (cu >= CH_UA && cu <= CH_UZ) dv = int'(cu) - int'(CH_UA) + 10;
      else if (cu >= CH_LA && cu <= CH_LZ) dv = int'(cu) - int'(CH_LA) + 10;
      else is_dig = 1'b0;
      if (!is_dig || dv >= abase) begin
        done = 1'b1;
      end else begin
        b = (abase != 0) ? 64'(abase) : 64'd1;
        if (acc > (MAG_CAP - 64'(dv)) / b) begin
          ovs = 1'b1;
          acc = MAG_CAP;
        end else begin
          acc = acc * b + 64'(dv);
        end
        ph = PH_DIGITS;
      end
    end
    if (done) begin
      r.ovf = ovs;
      if (neg) begin
        r.value = ovs ? MAG_CAP : -acc;
      end else if (ovs || acc >= MAG_CAP) begin
        r.ovf = 1'b1;
        r.value = INT_MAX;
      end else begin
        r.value = acc;
      end
      r.stop = pos[POS_W-1:0];
      ph = PH_FINISHED;
    end else if (pos < MAX_CHARS) begin
      pos++;
    end
  endtask

  // checker and predictor
  always @(posedge clk) begin : scoreboard
    conv_result_t got;
    conv_result_t want;
    conv_result_t pr;
    bit           made;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[63:0];
        got.stop  = out_tdata[76:64];
        got.ovf   = out_tdata[77];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value %0d stop %0d ovf %0b", $time,
                   $signed(got.value), got.stop, got.ovf);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time,
                     $signed(want.value), $signed(got.value));
            errors++;
          end
          if (got.stop !== want.stop) begin
            $display("%0t: stop_index expected %0d actual %0d", $time, want.stop, got.stop);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b", $time, want.ovf, got.ovf);
            errors++;
          end
        end
        rx_count++;
      end
      if (cfg_valid && cfg_ready) base_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        convert_unit(in_tdata, in_tuser, made, pr);
        if (tag_typed) pending_results.push_back(tag_exp);
        else if (made) pending_results.push_back(pr);
      end
    end
  end

  // output-side back-pressure; one long hold-off while the sender is busy
  always @(posedge clk) begin : out_pacing
    int hold_left;
    bit hold_done;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && rx_count >= 40 && in_tvalid) begin
      hold_done = 1'b1;
      hold_left = 90;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic send_unit(input logic [CU_W-1:0] cu, input logic fu,
                           input bit typed, input conv_result_t e);
    if (!steady && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cu;
    in_tuser  <= fu;
    tag_typed <= typed;
    tag_exp   <= e;
    do @(posedge clk); while (!in_tready);
  endtask

  // only once everything in flight has drained
  task automatic set_base(input logic [BASE_W-1:0] b);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    case_row_t         rows[$];
    case_row_t         row;
    conv_result_t      e;
    logic [BASE_W-1:0] bases[7];
    logic [BASE_W-1:0] b;
    logic [CU_W-1:0]   cu;
    int                n, k, sent, nws, pick, dig_base, lim, ndig, dv, ph_i;
    bit                lead;

    // after reset: units without a first flag are ignored
    rows.push_back('{-1, 0, 0, "123", 0, CH_NUL, 0, 0, 0, 0});
    // terminator as the very first unit
    rows.push_back('{-1, 0, 1, "", 1, CH_NUL, 1, 0, 0, 0});
    rows.push_back('{-1, 0, 1, "123", 1, CH_NUL, 1, 123, 3, 0});
    rows.push_back('{-1, 0, 1, "  -42", 1, CH_NUL, 1, -42, 5, 0});
    rows.push_back('{-1, 0, 1, "\011\012\013\014\015+7x", 0, CH_NUL, 1, 7, 7, 0});
    rows.push_back('{-1, 0, 1, "0x1fZ", 0, CH_NUL, 1, 31, 4, 0});
    rows.push_back('{-1, 0, 1, "0X", 1, CH_NUL, 1, 0, 2, 0});
    rows.push_back('{-1, 0, 1, "0777", 1, CH_NUL, 1, 511, 4, 0});
    rows.push_back('{-1, 0, 1, "08", 0, CH_NUL, 1, 0, 1, 0});
    // space or second sign after a sign stops at once
    rows.push_back('{-1, 0, 1, "- ", 0, CH_NUL, 1, 0, 1, 0});
    rows.push_back('{-1, 0, 1, "+-", 0, CH_NUL, 1, 0, 1, 0});
    rows.push_back('{-1, 0, 1, "9223372036854775807", 1, CH_NUL, 1, INT_MAX, 19, 0});
    rows.push_back('{-1, 0, 1, "9223372036854775808", 1, CH_NUL, 1, INT_MAX, 19, 1});
    rows.push_back('{-1, 0, 1, "-9223372036854775808", 1, CH_NUL, 1, MAG_CAP, 20, 0});
    rows.push_back('{-1, 0, 1, "-99999999999999999999", 1, CH_NUL, 1, MAG_CAP, 21, 1});
    // non-ASCII units stop even when the low byte looks like a digit
    rows.push_back('{-1, 0, 1, "12", 1, 16'hFFFF, 1, 12, 2, 0});
    rows.push_back('{-1, 0, 1, "12", 1, 16'h0132, 1, 12, 2, 0});
    rows.push_back('{16, 0, 1, "ff", 1, CH_NUL, 1, 255, 2, 0});
    rows.push_back('{36, 0, 1, "zZ", 1, CH_NUL, 1, 1295, 2, 0});
    // leading zero forces octal whatever the configured base
    rows.push_back('{-1, 0, 1, "010", 1, CH_NUL, 1, 8, 3, 0});
    rows.push_back('{1, 0, 1, "1", 0, CH_NUL, 1, 0, 0, 0});
    rows.push_back('{63, 0, 1, "Zz9", 1, CH_NUL, 0, 0, 0, 0});
    // abandoned string, then a fresh one, then ignored trailing units
    rows.push_back('{0, 0, 1, "12", 0, CH_NUL, 0, 0, 0, 0});
    rows.push_back('{-1, 0, 1, "34", 1, CH_NUL, 1, 34, 2, 0});
    rows.push_back('{-1, 0, 0, "55", 0, CH_NUL, 0, 0, 0, 0});
    // position saturates on a long run of spaces
    rows.push_back('{-1, 4200, 1, "7", 1, CH_NUL, 1, 7, MAX_CHARS, 0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.base >= 0) set_base(row.base[BASE_W-1:0]);
      n = row.pad + row.text.len() + int'(row.has_tail);
      e.value = row.v;
      e.stop  = row.stop[POS_W-1:0];
      e.ovf   = row.ovf;
      for (k = 0; k < n; k++) begin
        if (k < row.pad) cu = CH_SPACE;
        else if (k < row.pad + row.text.len()) cu = 16'(row.text[k - row.pad]);
        else cu = row.tail;
        send_unit(cu, row.lead && k == 0, row.typed && k == n - 1, e);
      end
    end

    bases = '{6'd10, 6'd0, 6'd2, 6'd36, 6'd63, 6'd16, 6'd0};
    sent = 0;
    for (ph_i = 0; ph_i < 7; ph_i++) begin
      steady = (ph_i == 0);
      b = (ph_i == 6) ? BASE_W'($urandom_range(0, 63)) : bases[ph_i];
      set_base(b);
      while (sent < (ph_i + 1) * 90) begin
        if ($urandom_range(0, 99) < 80) begin
          nws = $urandom_range(0, 2);
          for (k = 0; k < nws; k++) begin
            cu = $urandom_range(0, 1) ? CH_SPACE : CU_W'($urandom_range(9, 13));
            send_unit(cu, k == 0, 1'b0, '0);
            sent++;
          end
          lead = (nws == 0);
          pick = $urandom_range(0, 2);
          if (pick != 0) begin
            send_unit((pick == 1) ? CH_PLUS : CH_MINUS, lead, 1'b0, '0);
            lead = 1'b0;
            sent++;
          end
          dig_base = (b == 0) ? int'(BASE_DEC) : int'(b);
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            send_unit(CH_ZERO, lead, 1'b0, '0);
            send_unit($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0, 1'b0, '0);
            lead = 1'b0;
            sent += 2;
            dig_base = int'(BASE_HEX);
          end else if (pick < 25) begin
            send_unit(CH_ZERO, lead, 1'b0, '0);
            lead = 1'b0;
            sent++;
            dig_base = int'(BASE_OCT);
          end
          lim = (dig_base > 36) ? 36 : dig_base;
          // a fifth of the strings get a long digit run, which can overflow in the larger bases
          ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 8);
          for (k = 0; k < ndig; k++) begin
            dv = $urandom_range(0, lim - 1);
            if (dv < 10) cu = CU_W'(int'(CH_ZERO) + dv);
            else cu = CU_W'(int'($urandom_range(0, 1) ? CH_UA : CH_LA) + dv - 10);
            send_unit(cu, lead, 1'b0, '0);
            lead = 1'b0;
            sent++;
          end
          pick = $urandom_range(0, 99);
          if (pick >= 5) begin
            if (pick < 50) cu = CH_NUL;
            else if (pick < 80) cu = CU_W'($urandom_range(0, 65535));
            else if (lim < 10) cu = CU_W'(int'(CH_ZERO) + lim);
            else if (lim < 36) cu = CU_W'(int'(CH_UA) + lim - 10);
            else cu = CH_SPACE;
            send_unit(cu, lead, 1'b0, '0);
            sent++;
            // stray units after the result are ignored
            if ($urandom_range(0, 9) == 0) begin
              repeat ($urandom_range(1, 3))
                send_unit(CU_W'($urandom_range(0, 65535)), 1'b0, 1'b0, '0);
            end
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_unit(CU_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0,
                      1'b0, '0);
            sent++;
          end
        end
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
